// File: rtl/core/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT = 2'd2;

  localparam logic [15:0] PROCESS_NOISE_RST = 16'd256;
  localparam logic [15:0] MEAS_NOISE_RST = 16'd768;
  localparam logic [7:0] LOST_LIMIT_RST = 8'd20;

  localparam logic signed [15:0] LOST_LEVEL = -16'sd25600;
  localparam logic [7:0] SILENCE_MAX = 8'd255;
  localparam logic [15:0] GAIN_MAX = 16'hFFFF;

  localparam logic ACT_MEASURE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SEARCH = 9'b000000010,
    ST_PREP   = 9'b000000100,
    ST_DIV    = 9'b000001000,
    ST_MUL1   = 9'b000010000,
    ST_MUL2   = 9'b000100000,
    ST_MUL3   = 9'b001000000,
    ST_TICK   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

endpackage

// File: rtl/core/signal_strength_tracker_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports
// in        request    in_valid, in_stall, in_action, in_station_key, in_level
// out       result     out_valid, out_stall, out_kind .. out_last
// cfg       write      cfg_we, cfg_index, cfg_data
// A measurement: acceptance, a search of slots up to the match (to the end if
// absent; a full table gives table-full), a prepare state, 32 division steps
// (none if measurement noise is 0), three multiply/update states and an output
// state; new or re-armed entries skip to OUT. Ticks run TICK, OUT per entry.
// Reset is synchronous, clears the entry count and sequencer, loads config defaults.
// The input is stalled from acceptance until the last result is taken.

module signal_strength_tracker_unit #(
  parameter int SLOTS = 16,
  parameter int KEY_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [47:0]                   in_station_key,
  input  logic signed [15:0]            in_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [3:0]                    out_slot,
  output logic signed [15:0]            out_estimate,
  output logic signed [15:0]            out_raw_level,
  output logic                          out_new_entry,
  output logic                          out_table_full,
  output logic                          out_lost,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sst_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sst_pkg::*;

  localparam int KW = (KEY_BITS < 48) ? KEY_BITS : 48;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  state_t state_r;
  logic [15:0] q_noise_r, r_noise_r;
  logic [7:0] limit_r;

  logic [KW-1:0] keys_r [SLOTS];
  logic signed [15:0] est_r [SLOTS];
  logic [15:0] cov_r [SLOTS];
  logic signed [15:0] lvl_r [SLOTS];
  logic rearm_r [SLOTS];
  logic [7:0] sil_r [SLOTS];
  logic [CW-1:0] count_r;

  logic act_r;
  logic [KW-1:0] key_r;
  logic signed [15:0] z_r;
  logic [CW-1:0] idx_r;
  logic created_r;
  logic [15:0] p_r;
  logic [16:0] den_r;
  logic [16:0] rem_r;
  logic [31:0] dvd_r;
  logic [15:0] k_r;
  logic [4:0] step_r;
  logic signed [33:0] prod_r;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_y;
  logic [17:0] rem_sh;
  logic [16:0] p_sum;
  logic [SW-1:0] s;

  assign s = idx_r[SW-1:0];
  assign rem_sh = {rem_r, dvd_r[31]};
  assign p_sum = {1'b0, cov_r[s]} + {1'b0, q_noise_r};

  always_comb begin
    mul_a = signed'({1'b0, k_r});
    if (state_r == ST_MUL1) begin
      mul_b = 17'(z_r) - 17'(est_r[s]);
    end else begin
      mul_b = signed'({1'b0, p_r});
    end
  end
  assign mul_y = mul_a * mul_b;

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      q_noise_r <= PROCESS_NOISE_RST;
      r_noise_r <= MEAS_NOISE_RST;
      limit_r <= LOST_LIMIT_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROCESS_NOISE: q_noise_r <= cfg_data;
          REG_MEAS_NOISE:    r_noise_r <= cfg_data;
          REG_LOST_LIMIT:    limit_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            act_r <= in_action;
            key_r <= in_station_key[KW-1:0];
            z_r <= in_level;
            idx_r <= '0;
            created_r <= 1'b0;
            if (in_action == ACT_TICK) begin
              state_r <= (count_r == '0) ? ST_IDLE : ST_TICK;
            end else begin
              state_r <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (idx_r >= count_r) begin
            if (count_r == CW'(SLOTS)) begin
              out_kind <= ACT_MEASURE;
              out_slot <= '0;
              out_estimate <= '0;
              out_raw_level <= '0;
              out_new_entry <= 1'b0;
              out_table_full <= 1'b1;
              out_lost <= 1'b0;
              out_last <= 1'b1;
              state_r <= ST_OUT;
            end else begin
              count_r <= count_r + 1'b1;
              keys_r[s] <= key_r;
              rearm_r[s] <= 1'b1;
              created_r <= 1'b1;
              state_r <= ST_PREP;
            end
          end else if (keys_r[s] == key_r) begin
            state_r <= ST_PREP;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_PREP: begin
          lvl_r[s] <= z_r;
          sil_r[s] <= '0;
          if (rearm_r[s]) begin
            est_r[s] <= z_r;
            cov_r[s] <= r_noise_r;
            rearm_r[s] <= 1'b0;
            out_kind <= ACT_MEASURE;
            out_slot <= 4'(idx_r);
            out_estimate <= z_r;
            out_raw_level <= z_r;
            out_new_entry <= created_r;
            out_table_full <= 1'b0;
            out_lost <= 1'b0;
            out_last <= 1'b1;
            state_r <= ST_OUT;
          end else begin
            p_r <= p_sum[16] ? 16'hFFFF : p_sum[15:0];
            den_r <= (p_sum[16] ? 17'h0FFFF : p_sum) + {1'b0, r_noise_r};
            dvd_r <= {(p_sum[16] ? 16'hFFFF : p_sum[15:0]), 16'h0000};
            rem_r <= '0;
            step_r <= '0;
            if (r_noise_r == '0) begin
              k_r <= GAIN_MAX;
              state_r <= ST_MUL1;
            end else begin
              k_r <= '0;
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          dvd_r <= {dvd_r[30:0], 1'b0};
          if (rem_sh >= {1'b0, den_r}) begin
            rem_r <= 17'(rem_sh - {1'b0, den_r});
            k_r <= {k_r[14:0], 1'b1};
          end else begin
            rem_r <= rem_sh[16:0];
            k_r <= {k_r[14:0], 1'b0};
          end
          step_r <= step_r + 1'b1;
          if (step_r == 5'd31) begin
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          prod_r <= mul_y;
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          est_r[s] <= est_r[s] + 16'(prod_r >>> 16);
          out_estimate <= est_r[s] + 16'(prod_r >>> 16);
          prod_r <= mul_y;
          state_r <= ST_MUL3;
        end
        ST_MUL3: begin
          cov_r[s] <= p_r - prod_r[31:16];
          out_kind <= ACT_MEASURE;
          out_slot <= 4'(idx_r);
          out_raw_level <= z_r;
          out_new_entry <= 1'b0;
          out_table_full <= 1'b0;
          out_lost <= 1'b0;
          out_last <= 1'b1;
          state_r <= ST_OUT;
        end
        ST_TICK: begin
          out_kind <= ACT_TICK;
          out_slot <= 4'(idx_r);
          out_new_entry <= 1'b0;
          out_table_full <= 1'b0;
          out_last <= (idx_r + 1'b1 == count_r);
          if (sil_r[s] > limit_r) begin
            est_r[s] <= LOST_LEVEL;
            lvl_r[s] <= LOST_LEVEL;
            rearm_r[s] <= 1'b1;
            out_estimate <= LOST_LEVEL;
            out_raw_level <= LOST_LEVEL;
            out_lost <= 1'b1;
          end else begin
            out_estimate <= est_r[s];
            out_raw_level <= lvl_r[s];
            out_lost <= 1'b0;
          end
          if (sil_r[s] != SILENCE_MAX) begin
            sil_r[s] <= sil_r[s] + 1'b1;
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            if (act_r == ACT_TICK && !out_last) begin
              idx_r <= idx_r + 1'b1;
              state_r <= ST_TICK;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
